// ----- rtl/core/ple_pkg.sv -----
// ----------------------------------------------------------------------------
// ple_pkg
// Types and constants shared by the positional list engine.
// ----------------------------------------------------------------------------
package ple_pkg;

	localparam int CAPACITY   = 256;
	localparam int VALUE_BITS = 32;
	localparam int IDX_BITS   = $clog2(CAPACITY);
	localparam int SLOT_BITS  = IDX_BITS + 1;
	localparam logic [SLOT_BITS-1:0] NULL_SLOT = SLOT_BITS'(CAPACITY);

	typedef enum logic [2:0] {
		CMD_INS_FRONT = 3'd0,
		CMD_INS_AT    = 3'd1,
		CMD_INS_BACK  = 3'd2,
		CMD_DEL_FRONT = 3'd3,
		CMD_DEL_BACK  = 3'd4,
		CMD_DEL_AT    = 3'd5,
		CMD_SEARCH    = 3'd6,
		CMD_REVERSE   = 3'd7
	} cmd_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_BAD_POS   = 3'd1,
		ST_EMPTY     = 3'd2,
		ST_NOT_FOUND = 3'd3,
		ST_FULL      = 3'd4
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_WALK_REQ,
		S_WALK_WAIT,
		S_INS_LINK,
		S_DEL_READ,
		S_DEL_WAIT,
		S_DEL_LINK,
		S_SRCH_REQ,
		S_SRCH_WAIT,
		S_REV_REQ,
		S_REV_WAIT,
		S_FREE_WAIT,
		S_DONE
	} state_t;

	typedef struct packed {
		logic [2:0]           cmd;
		logic [31:0]          value;
		logic [SLOT_BITS-1:0] position;
	} req_t;

	typedef struct packed {
		logic [2:0]           status;
		logic [SLOT_BITS-1:0] found_position;
		logic [SLOT_BITS-1:0] entry_count;
	} rsp_t;

endpackage

// ----- rtl/core/ple_stream_if.sv -----
// ----------------------------------------------------------------------------
// ple_stream_if
// Valid/ready channel carrying one payload word.
// ----------------------------------------------------------------------------
interface ple_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/core/positional_list_engine.sv -----
// ----------------------------------------------------------------------------
// positional_list_engine
// Ordered list of signed words kept as linked slots in a node memory.
// ----------------------------------------------------------------------------
// One command is taken at a time and its result word is held until it is
// taken; the next command is accepted in the cycle after that. An error
// status is ready in the cycle after the command is accepted. A front insert
// passes through S_WALK_REQ and S_INS_LINK (first S_FREE_WAIT when a freed
// slot is reused), a front delete through S_WALK_REQ, S_DEL_READ and
// S_DEL_WAIT. Other commands walk the linked slots one slot at a time, and
// each step waits out the registered read of the node RAM, so a command's
// walk grows with its position or with the number of entries it covers.
module positional_list_engine (
	input  logic                clk,
	input  logic                arst_n,
	ple_stream_if.sink          in_ch,
	ple_stream_if.source        out_ch
);
	logic [ple_pkg::IDX_BITS-1:0]   addr;
	logic                           val_we, lnk_we;
	logic [ple_pkg::VALUE_BITS-1:0] val_wdata, val_rdata;
	logic [ple_pkg::SLOT_BITS-1:0]  lnk_wdata, lnk_rdata;

	ple_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.req_valid(in_ch.valid), .req_ready(in_ch.ready), .req(in_ch.data),
		.rsp_valid(out_ch.valid), .rsp_ready(out_ch.ready), .rsp(out_ch.data),
		.addr(addr), .val_we(val_we), .lnk_we(lnk_we),
		.val_wdata(val_wdata), .lnk_wdata(lnk_wdata),
		.val_rdata(val_rdata), .lnk_rdata(lnk_rdata)
	);

	ple_ram #(.WIDTH(ple_pkg::VALUE_BITS), .DEPTH(ple_pkg::CAPACITY)) u_val_ram (
		.clk(clk), .we(val_we), .addr(addr), .wdata(val_wdata), .rdata(val_rdata)
	);

	ple_ram #(.WIDTH(ple_pkg::SLOT_BITS), .DEPTH(ple_pkg::CAPACITY)) u_lnk_ram (
		.clk(clk), .we(lnk_we), .addr(addr), .wdata(lnk_wdata), .rdata(lnk_rdata)
	);

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> !in_ch.ready) else $error("accept while result pending");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> out_ch.data.entry_count <= ple_pkg::NULL_SLOT)
		else $error("entry count out of range");
	a_found_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && out_ch.data.found_position != '0)
		|-> out_ch.data.status == ple_pkg::ST_OK) else $error("found without ok");
endmodule

// ----- rtl/core/ple_ram.sv -----
// ----------------------------------------------------------------------------
// ple_ram
// Generic single-port synchronous RAM with registered read.
// ----------------------------------------------------------------------------
module ple_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end
endmodule

// ----- rtl/core/ple_ctrl.sv -----
// ----------------------------------------------------------------------------
// ple_ctrl
// Command sequencer: walks the linked slots and updates the node memory.
// ----------------------------------------------------------------------------
module ple_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_ready,
	input  ple_pkg::req_t                 req,
	output logic                          rsp_valid,
	input  logic                          rsp_ready,
	output ple_pkg::rsp_t                 rsp,
	output logic [ple_pkg::IDX_BITS-1:0]  addr,
	output logic                          val_we,
	output logic                          lnk_we,
	output logic [ple_pkg::VALUE_BITS-1:0] val_wdata,
	output logic [ple_pkg::SLOT_BITS-1:0] lnk_wdata,
	input  logic [ple_pkg::VALUE_BITS-1:0] val_rdata,
	input  logic [ple_pkg::SLOT_BITS-1:0] lnk_rdata
);
	localparam int SB = ple_pkg::SLOT_BITS;
	localparam int IB = ple_pkg::IDX_BITS;
	localparam int VB = ple_pkg::VALUE_BITS;

	ple_pkg::state_t state_q, state_d;
	logic [SB-1:0] head_q, head_d, free_q, free_d, fresh_q, fresh_d, len_q, len_d;
	logic [SB-1:0] cur_q, cur_d, prev_q, prev_d, cnt_q, cnt_d, node_q, node_d;
	logic [SB-1:0] tgt_q, tgt_d;
	logic [2:0]    cmd_q, cmd_d;
	logic [VB-1:0] val_q, val_d;
	logic          ins_q, ins_d;
	ple_pkg::rsp_t rsp_q, rsp_d;
	logic [SB:0]   len_p1;
	logic [SB-1:0] tpos;
	logic          inserting;

	assign req_ready = (state_q == ple_pkg::S_IDLE);
	assign rsp_valid = (state_q == ple_pkg::S_DONE);
	assign rsp       = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ple_pkg::S_IDLE;
			head_q  <= ple_pkg::NULL_SLOT;
			free_q  <= ple_pkg::NULL_SLOT;
			fresh_q <= '0;
			len_q   <= '0;
		end else begin
			state_q <= state_d;
			head_q  <= head_d;
			free_q  <= free_d;
			fresh_q <= fresh_d;
			len_q   <= len_d;
		end
	end

	always_ff @(posedge clk) begin
		cur_q  <= cur_d;
		prev_q <= prev_d;
		cnt_q  <= cnt_d;
		node_q <= node_d;
		tgt_q  <= tgt_d;
		cmd_q  <= cmd_d;
		val_q  <= val_d;
		ins_q  <= ins_d;
		rsp_q  <= rsp_d;
	end

	always_comb begin
		state_d = state_q;
		head_d = head_q; free_d = free_q; fresh_d = fresh_q; len_d = len_q;
		cur_d = cur_q; prev_d = prev_q; cnt_d = cnt_q; node_d = node_q;
		tgt_d = tgt_q; cmd_d = cmd_q; val_d = val_q; ins_d = ins_q; rsp_d = rsp_q;
		addr = cur_q[IB-1:0];
		val_we = 1'b0; lnk_we = 1'b0;
		val_wdata = val_q; lnk_wdata = '0;
		len_p1 = {1'b0, len_q} + 1'b1;
		tpos = '0;
		inserting = 1'b0;
		unique case (state_q)
			ple_pkg::S_IDLE: begin
				if (req_valid) begin
					cmd_d = req.cmd;
					val_d = req.value[VB-1:0];
					rsp_d = '{status: ple_pkg::ST_OK, found_position: '0, entry_count: len_q};
					cnt_d = SB'(1);
					cur_d = head_q;
					prev_d = ple_pkg::NULL_SLOT;
					state_d = ple_pkg::S_DONE;
					case (req.cmd) inside
						ple_pkg::CMD_INS_FRONT, ple_pkg::CMD_INS_AT, ple_pkg::CMD_INS_BACK: begin
							inserting = 1'b1;
							if (req.cmd == ple_pkg::CMD_INS_FRONT) tpos = SB'(1);
							else if (req.cmd == ple_pkg::CMD_INS_BACK) tpos = len_p1[SB-1:0];
							else tpos = req.position;
						end
						ple_pkg::CMD_DEL_FRONT, ple_pkg::CMD_DEL_BACK: begin
							if (len_q == '0) rsp_d.status = ple_pkg::ST_EMPTY;
							else begin
								tgt_d = (req.cmd == ple_pkg::CMD_DEL_FRONT) ? SB'(1) : len_q;
								state_d = ple_pkg::S_WALK_REQ;
								ins_d = 1'b0;
							end
						end
						ple_pkg::CMD_DEL_AT: begin
							if (req.position == '0) rsp_d.status = ple_pkg::ST_BAD_POS;
							else if (len_q == '0) rsp_d.status = ple_pkg::ST_EMPTY;
							else if (req.position > len_q) rsp_d.status = ple_pkg::ST_BAD_POS;
							else begin
								tgt_d = req.position;
								state_d = ple_pkg::S_WALK_REQ;
								ins_d = 1'b0;
							end
						end
						ple_pkg::CMD_SEARCH: begin
							rsp_d.status = ple_pkg::ST_NOT_FOUND;
							if (len_q != '0) state_d = ple_pkg::S_SRCH_REQ;
						end
						default: begin
							if (len_q != '0) state_d = ple_pkg::S_REV_REQ;
						end
					endcase
					if (inserting) begin
						if (tpos == '0 || {1'b0, tpos} > len_p1)
							rsp_d.status = ple_pkg::ST_BAD_POS;
						else if (len_q >= ple_pkg::NULL_SLOT)
							rsp_d.status = ple_pkg::ST_FULL;
						else begin
							tgt_d = tpos;
							ins_d = 1'b1;
							if (free_q != ple_pkg::NULL_SLOT) begin
								addr = free_q[IB-1:0];
								node_d = free_q;
								cur_d = free_q;
								state_d = ple_pkg::S_FREE_WAIT;
							end else begin
								node_d = fresh_q;
								fresh_d = fresh_q + 1'b1;
								state_d = ple_pkg::S_WALK_REQ;
							end
						end
					end
				end
			end
			ple_pkg::S_FREE_WAIT: begin
				free_d = lnk_rdata;
				cur_d = head_q;
				state_d = ple_pkg::S_WALK_REQ;
			end
			ple_pkg::S_WALK_REQ: begin
				// cur holds the slot at position cnt; stop at target-1.
				if (cnt_q + 1'b1 >= tgt_q) state_d = ins_q ? ple_pkg::S_INS_LINK
					: ple_pkg::S_DEL_READ;
				else state_d = ple_pkg::S_WALK_WAIT;
				if (tgt_q == SB'(1)) begin
					prev_d = ple_pkg::NULL_SLOT;
					state_d = ins_q ? ple_pkg::S_INS_LINK : ple_pkg::S_DEL_READ;
				end else prev_d = cur_q;
			end
			ple_pkg::S_WALK_WAIT: begin
				cur_d = lnk_rdata;
				cnt_d = cnt_q + 1'b1;
				state_d = ple_pkg::S_WALK_REQ;
			end
			ple_pkg::S_INS_LINK: begin
				addr = node_q[IB-1:0];
				val_we = 1'b1;
				lnk_we = 1'b1;
				if (prev_q == ple_pkg::NULL_SLOT) begin
					lnk_wdata = head_q;
					head_d = node_q;
					len_d = len_q + 1'b1;
					rsp_d.entry_count = len_q + 1'b1;
					state_d = ple_pkg::S_DONE;
				end else begin
					// First read prev's link, then write node, then prev.
					val_we = 1'b0; lnk_we = 1'b0;
					addr = prev_q[IB-1:0];
					state_d = ple_pkg::S_DEL_WAIT;
				end
			end
			ple_pkg::S_DEL_READ: begin
				if (prev_q == ple_pkg::NULL_SLOT) begin
					addr = head_q[IB-1:0];
					node_d = head_q;
					state_d = ple_pkg::S_DEL_WAIT;
				end else begin
					addr = prev_q[IB-1:0];
					state_d = ple_pkg::S_SRCH_WAIT;
				end
			end
			ple_pkg::S_SRCH_WAIT: begin
				if (cmd_q == ple_pkg::CMD_SEARCH) begin
					if (val_rdata == val_q) begin
						rsp_d.status = ple_pkg::ST_OK;
						rsp_d.found_position = cnt_q;
						state_d = ple_pkg::S_DONE;
					end else if (cnt_q >= len_q || lnk_rdata == ple_pkg::NULL_SLOT)
						state_d = ple_pkg::S_DONE;
					else begin
						cur_d = lnk_rdata;
						cnt_d = cnt_q + 1'b1;
						state_d = ple_pkg::S_SRCH_REQ;
					end
				end else begin
					node_d = lnk_rdata;
					addr = lnk_rdata[IB-1:0];
					state_d = ple_pkg::S_DEL_WAIT;
				end
			end
			ple_pkg::S_DEL_WAIT: begin
				if (ins_q) begin
					// lnk_rdata is prev's next; link node in, then prev.
					addr = node_q[IB-1:0];
					val_we = 1'b1; lnk_we = 1'b1;
					lnk_wdata = lnk_rdata;
					state_d = ple_pkg::S_DEL_LINK;
				end else begin
					// lnk_rdata is the victim's next.
					addr = node_q[IB-1:0];
					lnk_we = 1'b1;
					lnk_wdata = free_q;
					free_d = node_q;
					cur_d = lnk_rdata;
					if (prev_q == ple_pkg::NULL_SLOT) begin
						head_d = lnk_rdata;
						len_d = len_q - 1'b1;
						rsp_d.entry_count = len_q - 1'b1;
						state_d = ple_pkg::S_DONE;
					end else state_d = ple_pkg::S_DEL_LINK;
				end
			end
			ple_pkg::S_DEL_LINK: begin
				addr = prev_q[IB-1:0];
				lnk_we = 1'b1;
				lnk_wdata = ins_q ? node_q : cur_q;
				len_d = ins_q ? len_q + 1'b1 : len_q - 1'b1;
				rsp_d.entry_count = len_d;
				state_d = ple_pkg::S_DONE;
			end
			ple_pkg::S_SRCH_REQ: begin
				state_d = ple_pkg::S_SRCH_WAIT;
			end
			ple_pkg::S_REV_REQ: begin
				state_d = ple_pkg::S_REV_WAIT;
			end
			ple_pkg::S_REV_WAIT: begin
				lnk_we = 1'b1;
				lnk_wdata = prev_q;
				prev_d = cur_q;
				cur_d = lnk_rdata;
				cnt_d = cnt_q + 1'b1;
				if (cnt_q >= len_q || lnk_rdata == ple_pkg::NULL_SLOT) begin
					head_d = cur_q;
					state_d = ple_pkg::S_DONE;
				end else state_d = ple_pkg::S_REV_REQ;
			end
			ple_pkg::S_DONE: begin
				if (rsp_ready) state_d = ple_pkg::S_IDLE;
			end
			default: state_d = ple_pkg::S_IDLE;
		endcase
	end
endmodule

// ----- verif/tb_positional_list_engine.sv -----
// ----------------------------------------------------------------------------
// tb_positional_list_engine
// Self-checking testbench for the positional list engine. A queue-fed driver
// offers commands with random gaps, a monitor takes results with random
// stalls, and a behavioral list model predicts every result word.
// ----------------------------------------------------------------------------
module tb_positional_list_engine;

	logic clk;
	logic arst_n;

	ple_stream_if #(.payload_t(ple_pkg::req_t)) in_ch ();
	ple_stream_if #(.payload_t(ple_pkg::rsp_t)) out_ch ();

	positional_list_engine DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	ple_pkg::req_t pending_cmds[$];
	ple_pkg::rsp_t expected_rsps[$];
	int   error_count = 0;
	bit   quiet_tail = 0;
	int   send_gap = 0;
	int   recv_gap = 0;
	int   hold_off = 0;
	bit   hold_done = 0;
	int   rsp_count = 0;
	int   idle_cycles = 0;

	// Model of the list as an ordered array of stored words.
	logic [31:0] list_words[$];
	int          list_max = ple_pkg::CAPACITY;

	function automatic ple_pkg::rsp_t predict_list(ple_pkg::req_t r);
		ple_pkg::rsp_t o;
		int            pos;
		int            len;
		logic [31:0]   w;
		o = '0;
		o.status = ple_pkg::ST_OK;
		len = list_words.size();
		pos = r.position;
		case (ple_pkg::cmd_t'(r.cmd))
			ple_pkg::CMD_INS_FRONT, ple_pkg::CMD_INS_AT, ple_pkg::CMD_INS_BACK: begin
				if (r.cmd == ple_pkg::CMD_INS_FRONT) pos = 1;
				if (r.cmd == ple_pkg::CMD_INS_BACK) pos = len + 1;
				if (pos == 0 || pos > len + 1) o.status = ple_pkg::ST_BAD_POS;
				else if (len >= list_max) o.status = ple_pkg::ST_FULL;
				else list_words.insert(pos - 1, r.value);
			end
			ple_pkg::CMD_DEL_FRONT, ple_pkg::CMD_DEL_BACK: begin
				if (len == 0) o.status = ple_pkg::ST_EMPTY;
				else if (r.cmd == ple_pkg::CMD_DEL_FRONT) void'(list_words.pop_front());
				else void'(list_words.pop_back());
			end
			ple_pkg::CMD_DEL_AT: begin
				if (pos == 0) o.status = ple_pkg::ST_BAD_POS;
				else if (len == 0) o.status = ple_pkg::ST_EMPTY;
				else if (pos > len) o.status = ple_pkg::ST_BAD_POS;
				else list_words.delete(pos - 1);
			end
			ple_pkg::CMD_SEARCH: begin
				o.status = ple_pkg::ST_NOT_FOUND;
				for (int i = 0; i < len; i++) begin
					if (list_words[i] == r.value) begin
						o.status = ple_pkg::ST_OK;
						o.found_position = ple_pkg::SLOT_BITS'(i + 1);
						break;
					end
				end
			end
			default: begin
				for (int i = 0; i < len / 2; i++) begin
					w = list_words[i];
					list_words[i] = list_words[len - 1 - i];
					list_words[len - 1 - i] = w;
				end
			end
		endcase
		o.entry_count = ple_pkg::SLOT_BITS'(list_words.size());
		return o;
	endfunction

	function automatic ple_pkg::req_t make_cmd(ple_pkg::cmd_t c, logic [31:0] v, int p);
		ple_pkg::req_t r;
		r.cmd = c;
		r.value = v;
		r.position = ple_pkg::SLOT_BITS'(p);
		return r;
	endfunction

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	// Driver.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
			in_ch.data  <= '0;
			send_gap    <= 0;
		end else begin
			if (in_ch.valid && in_ch.ready) begin
				expected_rsps.push_back(predict_list(in_ch.data));
			end
			if (!in_ch.valid || in_ch.ready) begin
				if (send_gap > 0) begin
					send_gap <= send_gap - 1;
					in_ch.valid <= 1'b0;
				end else if (pending_cmds.size() > 0) begin
					in_ch.valid <= 1'b1;
					in_ch.data  <= pending_cmds.pop_front();
					if (!quiet_tail && $urandom_range(0, 9) == 0)
						send_gap <= $urandom_range(1, 14);
				end else begin
					in_ch.valid <= 1'b0;
				end
			end
		end
	end

	// Monitor.
	always @(posedge clk or negedge arst_n) begin
		ple_pkg::rsp_t e;
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
			recv_gap     <= 0;
			hold_off     <= 0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				rsp_count++;
				if (expected_rsps.size() == 0) begin
					$display("%0t: unexpected result %p", $time, out_ch.data);
					error_count++;
				end else begin
					e = expected_rsps.pop_front();
					if (out_ch.data.status !== e.status)
						$display("%0t: status expected %0d actual %0d", $time,
							e.status, out_ch.data.status);
					if (out_ch.data.found_position !== e.found_position)
						$display("%0t: found_position expected %0d actual %0d",
							$time, e.found_position, out_ch.data.found_position);
					if (out_ch.data.entry_count !== e.entry_count)
						$display("%0t: entry_count expected %0d actual %0d", $time,
							e.entry_count, out_ch.data.entry_count);
					if (out_ch.data !== e) error_count++;
				end
			end
			if (hold_off > 0) begin
				hold_off <= hold_off - 1;
				out_ch.ready <= 1'b0;
			end else if (!hold_done && rsp_count >= 200) begin
				hold_done <= 1'b1;
				hold_off  <= 3000;
				out_ch.ready <= 1'b0;
			end else if (recv_gap > 0) begin
				recv_gap <= recv_gap - 1;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= 1'b1;
				if (!quiet_tail && $urandom_range(0, 9) == 0)
					recv_gap <= $urandom_range(1, 14);
			end
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 20000) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	task automatic add_random(int n, int fill_bias);
		ple_pkg::cmd_t c;
		logic [31:0]   v;
		int            p;
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(0, 9))
				0, 1: c = ple_pkg::CMD_INS_BACK;
				2: c = ple_pkg::CMD_INS_FRONT;
				3: c = ple_pkg::CMD_INS_AT;
				4: c = (fill_bias != 0) ? ple_pkg::CMD_INS_BACK : ple_pkg::CMD_DEL_FRONT;
				5: c = (fill_bias != 0) ? ple_pkg::CMD_INS_AT : ple_pkg::CMD_DEL_BACK;
				6: c = ple_pkg::CMD_DEL_AT;
				7, 8: c = ple_pkg::CMD_SEARCH;
				default: c = ple_pkg::CMD_REVERSE;
			endcase
			if ($urandom_range(0, 2) == 0) v = $urandom;
			else v = $urandom_range(0, 15);
			if ($urandom_range(0, 5) == 0) p = $urandom_range(0, 511);
			else p = $urandom_range(0, 24);
			pending_cmds.push_back(make_cmd(c, v, p));
		end
	endtask

	initial begin
		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: empty list cases, extremes, every command.
		pending_cmds.push_back(make_cmd(ple_pkg::CMD_DEL_FRONT, 0, 0));
		pending_cmds.push_back(make_cmd(ple_pkg::CMD_DEL_BACK, 0, 0));
		pending_cmds.push_back(make_cmd(ple_pkg::CMD_DEL_AT, 0, 0));
		pending_cmds.push_back(make_cmd(ple_pkg::CMD_DEL_AT, 0, 1));
		pending_cmds.push_back(make_cmd(ple_pkg::CMD_SEARCH, 0, 0));
		pending_cmds.push_back(make_cmd(ple_pkg::CMD_REVERSE, 0, 0));
		pending_cmds.push_back(make_cmd(ple_pkg::CMD_INS_AT, 5, 0));
		pending_cmds.push_back(make_cmd(ple_pkg::CMD_INS_AT, 5, 2));
		pending_cmds.push_back(make_cmd(ple_pkg::CMD_INS_AT, 32'h8000_0000, 1));
		pending_cmds.push_back(make_cmd(ple_pkg::CMD_REVERSE, 0, 0));
		pending_cmds.push_back(make_cmd(ple_pkg::CMD_INS_FRONT, 32'h7FFF_FFFF, 511));
		pending_cmds.push_back(make_cmd(ple_pkg::CMD_INS_BACK, 32'hFFFF_FFFF, 256));
		pending_cmds.push_back(make_cmd(ple_pkg::CMD_INS_AT, 0, 4));
		pending_cmds.push_back(make_cmd(ple_pkg::CMD_INS_AT, 1, 5));
		pending_cmds.push_back(make_cmd(ple_pkg::CMD_SEARCH, 32'hFFFF_FFFF, 0));
		pending_cmds.push_back(make_cmd(ple_pkg::CMD_SEARCH, 32'h1234_5678, 0));
		pending_cmds.push_back(make_cmd(ple_pkg::CMD_REVERSE, 0, 0));
		pending_cmds.push_back(make_cmd(ple_pkg::CMD_DEL_AT, 0, 0));
		pending_cmds.push_back(make_cmd(ple_pkg::CMD_DEL_AT, 0, 5));
		pending_cmds.push_back(make_cmd(ple_pkg::CMD_DEL_AT, 0, 2));
		pending_cmds.push_back(make_cmd(ple_pkg::CMD_DEL_BACK, 0, 0));
		pending_cmds.push_back(make_cmd(ple_pkg::CMD_DEL_FRONT, 0, 0));
		pending_cmds.push_back(make_cmd(ple_pkg::CMD_SEARCH, 32'h8000_0000, 0));

		add_random(600, 0);
		// Fill up to capacity, hit the full status, then drain through deletes.
		for (int i = 0; i < ple_pkg::CAPACITY + 4; i++)
			pending_cmds.push_back(make_cmd(ple_pkg::CMD_INS_BACK, $urandom, 0));
		pending_cmds.push_back(make_cmd(ple_pkg::CMD_INS_AT, 7, 256));
		pending_cmds.push_back(make_cmd(ple_pkg::CMD_INS_AT, 7, 257));
		pending_cmds.push_back(make_cmd(ple_pkg::CMD_DEL_AT, 0, 256));
		pending_cmds.push_back(make_cmd(ple_pkg::CMD_INS_AT, 9, 256));
		pending_cmds.push_back(make_cmd(ple_pkg::CMD_SEARCH, 9, 0));
		pending_cmds.push_back(make_cmd(ple_pkg::CMD_REVERSE, 0, 0));
		pending_cmds.push_back(make_cmd(ple_pkg::CMD_SEARCH, 9, 0));
		for (int i = 0; i < ple_pkg::CAPACITY + 2; i++)
			pending_cmds.push_back(make_cmd($urandom_range(0, 1) ? ple_pkg::CMD_DEL_FRONT
				: ple_pkg::CMD_DEL_BACK, 0, 0));
		add_random(500, 0);

		wait (pending_cmds.size() == 0);
		quiet_tail = 1'b1;
		add_random(150, 0);
		wait (pending_cmds.size() == 0 && !in_ch.valid);
		wait (expected_rsps.size() == 0);
		repeat (1200) @(posedge clk);
		if (error_count == 0 && expected_rsps.size() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end
endmodule
